[sv/smpq_pkg.sv]
// Shared types and codes for the sorted min-first priority queue.
`default_nettype none
package smpq_pkg;

  localparam logic       OP_ENQ = 1'b0;
  localparam logic       OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic enq;
    logic deq;
  } cmd_t;

endpackage
`default_nettype wire

[sv/smpq_cell.sv]
// One compare-and-shift cell of the sorted queue row.
`default_nettype none
module smpq_cell import smpq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  input  wire logic [DATA_WIDTH-1:0] new_val_i,
  input  wire logic                  left_ins_i,
  input  wire logic [DATA_WIDTH-1:0] left_val_i,
  input  wire logic                  left_valid_i,
  input  wire logic [DATA_WIDTH-1:0] right_val_i,
  input  wire logic                  right_valid_i,
  output      logic                  ins_o,
  output      logic [DATA_WIDTH-1:0] val_o,
  output      logic                  valid_o
);

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  valid_q, valid_d;

  // new item goes ahead of the first held value that is not smaller
  assign ins_o = !valid_q || !($signed(val_q) < $signed(new_val_i));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (cmd_i.enq && ins_o) begin
      if (left_ins_i) begin
        val_d   = left_val_i;
        valid_d = left_valid_i;
      end else begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.deq) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

[sv/sorted_min_priority_queue.sv]
// Sorted min-first priority queue: top level with the row of cells.
//
// One item (enqueue or dequeue) is accepted in every cycle; busy_o stays low.
// Every item yields one result, shown with done_o in the cycle after the item
// is taken. Each compare-and-shift cell of the row compares against the
// broadcast value and shifts. Enqueue on a full queue is dropped and flagged;
// dequeue on an empty queue returns 0 and is flagged.
`default_nettype none
module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] value_i,
  output      logic        done_o,
  output      logic [31:0] out_value_o,
  output      logic [4:0]  count_o,
  output      logic [1:0]  status_o
);

  localparam int OccW = $clog2(DEPTH + 1);

  logic                  accept;
  logic [OccW-1:0]       occ_q, occ_d;
  logic                  full, empty;
  cmd_t                  cmd;
  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH-1:0] new_val;

  logic [DEPTH-1:0]      ins;
  logic [DEPTH-1:0]      valid;
  logic [DATA_WIDTH-1:0] vals [DEPTH];

  logic                  done_q;
  logic [31:0]           out_value_q, out_value_d;
  logic [1:0]            status_q, status_d;
  logic [DATA_WIDTH+31:0] res_ext;
  logic [OccW+4:0]       occ_ext;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign full    = (occ_q == OccW'(DEPTH));
  assign empty   = (occ_q == '0);
  assign val_ext = {{DATA_WIDTH{value_i[31]}}, value_i};
  assign new_val = val_ext[DATA_WIDTH-1:0];

  assign cmd.enq = accept && (opcode_i == OP_ENQ) && !full;
  assign cmd.deq = accept && (opcode_i == OP_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_ins;
    logic [DATA_WIDTH-1:0] l_val;
    logic                  l_valid;
    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_valid;
    if (i == 0) begin : g_first
      assign l_ins   = 1'b0;
      assign l_val   = new_val;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_ins   = ins[i-1];
      assign l_val   = vals[i-1];
      assign l_valid = valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_val   = new_val;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = vals[i+1];
      assign r_valid = valid[i+1];
    end
    smpq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_val_i    (new_val),
      .left_ins_i   (l_ins),
      .left_val_i   (l_val),
      .left_valid_i (l_valid),
      .right_val_i  (r_val),
      .right_valid_i(r_valid),
      .ins_o        (ins[i]),
      .val_o        (vals[i]),
      .valid_o      (valid[i])
    );
  end

  assign res_ext = {32'b0, vals[0]};

  always_comb begin
    occ_d       = occ_q;
    out_value_d = '0;
    status_d    = ST_OK;
    if (accept) begin
      if (opcode_i == OP_ENQ) begin
        if (full) status_d = ST_FULL;
        else      occ_d    = occ_q + OccW'(1);
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d       = occ_q - OccW'(1);
          out_value_d = res_ext[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    status_q    <= status_d;
  end

  assign occ_ext     = {5'b0, occ_q};
  assign done_o      = done_q;
  assign out_value_o = out_value_q;
  assign count_o     = occ_ext[4:0];
  assign status_o    = status_q;

`ifndef ASSERT_OFF
  a_occ_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == int'(occ_q))
    else $error("occupancy does not match held cells");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid & ~(valid >> 1)) == (valid ^ (valid >> 1)) && ((valid + 1'b1) & valid) == '0)
    else $error("held cells not packed from the head");

  a_one_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("item gave no result");

  a_empty_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (occ_q == '0 && out_value_o == '0))
    else $error("empty dequeue with stored items");
`endif

endmodule
`default_nettype wire
